### sv/qpht_pkg.sv
package qpht_pkg;

  localparam int FUNC_W = 2;
  localparam int KEY_W = 31;
  localparam int IDX_W = 10;
  localparam int SIZE_W = 11;
  localparam int DIV_W = 8;
  localparam int CNT_W = 12;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 11;

  localparam int DEFAULT_DEPTH = 1024;
  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = SIZE_W'(16);
  localparam logic [DIV_W-1:0] HASH_DIV_RST = DIV_W'(11);

  // remainder bits retired per divider cycle
  localparam int DIV_STEPS = 4;
  localparam int DVD_W = 32;
  localparam int KEY_CYC = DVD_W / DIV_STEPS;
  localparam int HOME_CYC = DIV_W / DIV_STEPS;
  localparam int DCNT_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_TABLE_SIZE = 1'b0,
    CFG_HASH_DIV   = 1'b1
  } cfg_reg_t;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_CLEAR    = 8'b0000_0010,
    ST_DIV_KEY  = 8'b0000_0100,
    ST_DIV_HOME = 8'b0000_1000,
    ST_ISSUE    = 8'b0001_0000,
    ST_CHECK    = 8'b0010_0000,
    ST_RD_ISSUE = 8'b0100_0000,
    ST_RD_DATA  = 8'b1000_0000
  } state_t;

  // (a + b) mod m for a, b already below m
  function automatic logic [SIZE_W-1:0] mod_add(input logic [SIZE_W-1:0] a,
                                                input logic [SIZE_W-1:0] b,
                                                input logic [SIZE_W-1:0] m);
    logic [SIZE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[SIZE_W-1:0];
  endfunction

endpackage

### sv/quadratic_probe_hash_table.sv
// Open-addressing hash table with bidirectional quadratic probing.
// Issue an item by raising start with func, key and slot_index while busy is
// low; the item is taken at that clock edge and busy rises the next cycle.
// One result per item appears on the result ports with done high for exactly
// one cycle; the fields hold until the next result. busy drops in the done
// cycle, so the next item can be issued there. The receiver cannot stall.
// Configuration (table_size, hash_divisor) is written through cfg_we, cfg_addr
// and cfg_wdata; the user must write it only while the block is idle, since the block itself does not enforce this.
// Steps from accept to done:
//   insert/search: the home slot comes from the shared divider (4 remainder
//     bits a cycle), and each probe is one memory read (ST_ISSUE) followed
//     by one compare (ST_CHECK).
//   read: one memory read.
//   clear: one valid bit written per cycle.
// After reset the block runs the same sweep over all TABLE_DEPTH slots with
// busy high and gives no result; config writes are taken during it.
module quadratic_probe_hash_table #(
  parameter int TABLE_DEPTH = qpht_pkg::DEFAULT_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [qpht_pkg::FUNC_W-1:0]      func,
  input  logic [qpht_pkg::KEY_W-1:0]       key,
  input  logic [qpht_pkg::IDX_W-1:0]       slot_index,
  output logic                             done,
  output logic                             found,
  output logic [qpht_pkg::CNT_W-1:0]       probe_count,
  output logic [qpht_pkg::SIZE_W-1:0]      position,
  output logic [qpht_pkg::KEY_W-1:0]       slot_value,
  output logic                             slot_full,
  output logic                             status,
  input  logic                             cfg_we,
  input  logic [qpht_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [qpht_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import qpht_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

  logic              valid_mem [TABLE_DEPTH];
  logic [KEY_W-1:0]  key_mem   [TABLE_DEPTH];

  state_t            state;
  logic [SIZE_W-1:0] table_size;
  logic [DIV_W-1:0]  hash_divisor;
  logic [SIZE_W-1:0] eff_size;
  logic [SIZE_W-1:0] size_m1;
  logic [SIZE_W-1:0] div_eff;

  logic              clr_result;
  logic [AW-1:0]     clr_addr;
  func_t             func_q;
  logic [KEY_W-1:0]  key_q;
  logic [IDX_W-1:0]  idx_q;
  logic              in_range;

  logic [DVD_W-1:0]  dvd;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W-1:0] dvs;
  logic [DCNT_W-1:0] dcnt;
  logic [DVD_W-1:0]  dvd_next;
  logic [SIZE_W-1:0] rem_next;

  logic [SIZE_W-1:0] home;
  logic [SIZE_W-1:0] d;
  logic              side;
  logic [SIZE_W-1:0] sq;
  logic [SIZE_W-1:0] inc;
  logic [CNT_W-1:0]  cnt;
  logic [SIZE_W-1:0] pos;
  logic [SIZE_W-1:0] pos_next;
  logic              last_probe;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              valid_rd;
  logic [KEY_W-1:0]  key_rd;

  assign busy = (state != ST_IDLE);

  always_comb begin
    eff_size = table_size;
    if (table_size == '0) eff_size = SIZE_W'(1);
    else if (32'(table_size) > 32'(TABLE_DEPTH)) eff_size = SIZE_W'(TABLE_DEPTH);
    size_m1 = eff_size - SIZE_W'(1);
    div_eff = (hash_divisor == '0) ? SIZE_W'(1) : {{(SIZE_W-DIV_W){1'b0}}, hash_divisor};
  end

  // restoring remainder, DIV_STEPS dividend bits per cycle
  always_comb begin
    logic [SIZE_W:0] r;
    r = {1'b0, rem};
    dvd_next = dvd;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r = {r[SIZE_W-1:0], dvd_next[DVD_W-1]};
      dvd_next = {dvd_next[DVD_W-2:0], 1'b0};
      if (r >= {1'b0, dvs}) r = r - {1'b0, dvs};
    end
    rem_next = r[SIZE_W-1:0];
  end

  // probe slot for the current offset and side
  always_comb begin
    logic [SIZE_W:0] t;
    if (!side) begin
      t = {1'b0, home} + {1'b0, sq};
      if (t >= {1'b0, eff_size}) t = t - {1'b0, eff_size};
    end else if (home >= sq) begin
      t = {1'b0, home} - {1'b0, sq};
    end else begin
      t = {1'b0, home} + {1'b0, eff_size} - {1'b0, sq};
    end
    pos_next = t[SIZE_W-1:0];
  end

  assign last_probe = (side || d == '0) && (d == size_m1);

  always_comb begin
    rd_en = 1'b0;
    rd_addr = AW'(pos_next);
    if (state == ST_ISSUE) begin
      rd_en = 1'b1;
    end else if (state == ST_RD_ISSUE) begin
      rd_en = 1'b1;
      rd_addr = AW'(idx_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      valid_rd <= valid_mem[rd_addr];
      key_rd <= key_mem[rd_addr];
    end
    if (state == ST_CLEAR) begin
      valid_mem[clr_addr] <= 1'b0;
    end else if (state == ST_CHECK && func_q == FUNC_INSERT && !valid_rd) begin
      valid_mem[AW'(pos)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CHECK && func_q == FUNC_INSERT && !valid_rd) begin
      key_mem[AW'(pos)] <= key_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TABLE_SIZE_RST;
      hash_divisor <= HASH_DIV_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_TABLE_SIZE: table_size <= cfg_wdata[SIZE_W-1:0];
        CFG_HASH_DIV:   hash_divisor <= cfg_wdata[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      clr_result <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            func_q <= func_t'(func);
            key_q <= key;
            idx_q <= slot_index;
            case (func_t'(func))
              FUNC_CLEAR: begin
                state <= ST_CLEAR;
                clr_addr <= '0;
                clr_result <= 1'b1;
              end
              FUNC_READ: state <= ST_RD_ISSUE;
              default: begin
                state <= ST_DIV_KEY;
                dvd <= {1'b0, key};
                rem <= '0;
                dvs <= div_eff;
                dcnt <= '0;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
            if (clr_result) begin
              done <= 1'b1;
              found <= 1'b0;
              probe_count <= '0;
              position <= '0;
              slot_value <= '0;
              slot_full <= 1'b0;
              status <= 1'b0;
            end
          end
        end
        ST_DIV_KEY: begin
          dvd <= dvd_next;
          rem <= rem_next;
          dcnt <= dcnt + DCNT_W'(1);
          if (dcnt == DCNT_W'(KEY_CYC - 1)) begin
            // reduce key mod divisor again, now by the table size
            state <= ST_DIV_HOME;
            dvd <= {rem_next[DIV_W-1:0], {(DVD_W-DIV_W){1'b0}}};
            rem <= '0;
            dvs <= eff_size;
            dcnt <= '0;
          end
        end
        ST_DIV_HOME: begin
          dvd <= dvd_next;
          rem <= rem_next;
          dcnt <= dcnt + DCNT_W'(1);
          if (dcnt == DCNT_W'(HOME_CYC - 1)) begin
            state <= ST_ISSUE;
            home <= rem_next;
            d <= '0;
            side <= 1'b0;
            sq <= '0;
            inc <= (eff_size == SIZE_W'(1)) ? '0 : SIZE_W'(1);
            cnt <= '0;
          end
        end
        ST_ISSUE: begin
          pos <= pos_next;
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (!valid_rd || (func_q == FUNC_SEARCH && key_rd == key_q) || last_probe) begin
            state <= ST_IDLE;
            done <= 1'b1;
            found <= 1'b0;
            position <= '0;
            status <= 1'b0;
            slot_value <= '0;
            slot_full <= 1'b0;
            probe_count <= (func_q == FUNC_SEARCH) ? cnt + CNT_W'(1) : '0;
            if (!valid_rd) begin
              if (func_q == FUNC_INSERT) position <= pos + SIZE_W'(1);
            end else if (func_q == FUNC_SEARCH && key_rd == key_q) begin
              found <= 1'b1;
              position <= pos + SIZE_W'(1);
            end else begin
              status <= 1'b1;
            end
          end else begin
            state <= ST_ISSUE;
            cnt <= cnt + CNT_W'(1);
            if (!side && d != '0) begin
              side <= 1'b1;
            end else begin
              // advance offset: sq tracks d*d, inc tracks 2d+1, both mod size
              side <= 1'b0;
              d <= d + SIZE_W'(1);
              sq <= mod_add(sq, inc, eff_size);
              inc <= mod_add(mod_add(inc, SIZE_W'(1), eff_size), SIZE_W'(1), eff_size);
            end
          end
        end
        ST_RD_ISSUE: begin
          in_range <= ({1'b0, idx_q} < eff_size);
          state <= ST_RD_DATA;
        end
        ST_RD_DATA: begin
          state <= ST_IDLE;
          done <= 1'b1;
          found <= 1'b0;
          probe_count <= '0;
          position <= '0;
          status <= 1'b0;
          slot_full <= in_range && valid_rd;
          slot_value <= (in_range && valid_rd) ? key_rd : '0;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
